@@ design/crke_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package crke_pkg;

   localparam int IN_W      = 16;
   localparam int S_W       = 33;
   localparam int R_W       = 21;
   localparam int V_W       = 42;
   localparam int P_W       = 31;
   localparam int N_W       = 40;
   localparam int Q_W       = 31;
   localparam int DC_W      = R_W + Q_W;
   localparam int LANES     = 6;
   localparam int SQ_STAGES = R_W;
   localparam int DV_STAGES = Q_W;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_USE_OFFSET    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_SQUARE = 8'd1;

   // Lane order: xx, yy, zz, xy, xz, yz.
   localparam int LANE_XX = 0;
   localparam int LANE_YY = 1;
   localparam int LANE_ZZ = 2;
   localparam int LANE_XY = 3;
   localparam int LANE_XZ = 4;
   localparam int LANE_YZ = 5;

   typedef struct packed {
      logic signed [IN_W-1:0] pos_x;
      logic signed [IN_W-1:0] pos_y;
      logic signed [IN_W-1:0] pos_z;
   } crke_req_type;

   typedef struct packed {
      logic        [33:0] kernel_value;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic signed [31:0] grad_z;
      logic signed [31:0] hess_xx;
      logic signed [31:0] hess_yy;
      logic signed [31:0] hess_zz;
      logic signed [31:0] hess_xy;
      logic signed [31:0] hess_xz;
      logic signed [31:0] hess_yz;
   } crke_rsp_type;

   typedef struct packed {
      logic signed [IN_W-1:0]  x;
      logic signed [IN_W-1:0]  y;
      logic signed [IN_W-1:0]  z;
      logic [S_W-1:0]          s;
      logic [LANES-1:0][P_W-1:0] pmag;
      logic [LANES-1:0]        pneg;
   } crke_item_type;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
      logic [S_W-1:0]         s;
      logic [R_W-1:0]         r;
      logic [LANES-1:0]       pneg;
      logic [LANES-1:0]       ovf;
   } crke_tail_type;

endpackage
`default_nettype wire

@@ design/crke_sqrt_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crke_sqrt_pipe (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  adv,
   input  wire                  in_valid,
   input  crke_pkg::crke_item_type in_item,
   output logic                 out_valid,
   output logic [crke_pkg::R_W-1:0] out_root,
   output crke_pkg::crke_item_type out_item
);
   import crke_pkg::*;

   logic                valid_ff [0:SQ_STAGES-1];
   logic [V_W-1:0]      rem_ff   [0:SQ_STAGES-1];
   logic [R_W-1:0]      root_ff  [0:SQ_STAGES-1];
   crke_item_type       item_ff  [0:SQ_STAGES-1];

   // One root bit per stage, most significant first, on the radicand s * 2^8.
   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
      localparam int K = SQ_STAGES - 1 - g;
      logic           vld_cur;
      logic [V_W-1:0] rem_cur;
      logic [R_W-1:0] root_cur;
      crke_item_type  item_cur;
      logic [V_W-1:0] trial;
      logic [V_W-1:0] rem_in;
      logic [R_W-1:0] root_in;

      if (g == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rem_cur  = {{(V_W-S_W-8){1'b0}}, in_item.s, 8'h00};
         assign root_cur = '0;
         assign item_cur = in_item;
      end else begin : g_next
         assign vld_cur  = valid_ff[g-1];
         assign rem_cur  = rem_ff[g-1];
         assign root_cur = root_ff[g-1];
         assign item_cur = item_ff[g-1];
      end

      assign trial = ({{(V_W-R_W){1'b0}}, root_cur} << (K + 1))
                   | ({{(V_W-1){1'b0}}, 1'b1} << (2 * K));

      always_comb begin
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            root_in = root_cur | ({{(R_W-1){1'b0}}, 1'b1} << K);
         end else begin
            rem_in  = rem_cur;
            root_in = root_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (adv) begin
            valid_ff[g] <= vld_cur;
         end
         if (adv) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            item_ff[g] <= item_cur;
         end
      end
   end

   assign out_valid = valid_ff[SQ_STAGES-1];
   assign out_root  = root_ff[SQ_STAGES-1];
   assign out_item  = item_ff[SQ_STAGES-1];

endmodule
`default_nettype wire

@@ design/crke_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crke_div_pipe (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  adv,
   input  wire                  in_valid,
   input  crke_pkg::crke_tail_type in_tail,
   input  wire [crke_pkg::LANES-1:0][crke_pkg::N_W-1:0] in_num,
   output logic                 out_valid,
   output crke_pkg::crke_tail_type out_tail,
   output logic [crke_pkg::LANES-1:0][crke_pkg::Q_W-1:0] out_quot
);
   import crke_pkg::*;

   logic                           valid_ff [0:DV_STAGES-1];
   crke_tail_type                  tail_ff  [0:DV_STAGES-1];
   logic [LANES-1:0][N_W-1:0]      rem_ff   [0:DV_STAGES-1];
   logic [LANES-1:0][Q_W-1:0]      quot_ff  [0:DV_STAGES-1];

   // Restoring division, one quotient bit per stage for all six lanes. A
   // quotient of 2^31 or more is caught by the overflow flag upstream.
   for (genvar g = 0; g < DV_STAGES; g++) begin : g_stage
      localparam int K = DV_STAGES - 1 - g;
      logic                      vld_cur;
      crke_tail_type             tail_cur;
      logic [LANES-1:0][N_W-1:0] rem_cur;
      logic [LANES-1:0][Q_W-1:0] quot_cur;
      logic [LANES-1:0][N_W-1:0] rem_in;
      logic [LANES-1:0][Q_W-1:0] quot_in;
      logic [DC_W-1:0]           dvs;

      if (g == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign tail_cur = in_tail;
         assign rem_cur  = in_num;
         assign quot_cur = '0;
      end else begin : g_next
         assign vld_cur  = valid_ff[g-1];
         assign tail_cur = tail_ff[g-1];
         assign rem_cur  = rem_ff[g-1];
         assign quot_cur = quot_ff[g-1];
      end

      assign dvs = {{(DC_W-R_W){1'b0}}, tail_cur.r} << K;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if ({{(DC_W-N_W){1'b0}}, rem_cur[l]} >= dvs) begin
               rem_in[l]  = rem_cur[l] - dvs[N_W-1:0];
               quot_in[l] = quot_cur[l] | ({{(Q_W-1){1'b0}}, 1'b1} << K);
            end else begin
               rem_in[l]  = rem_cur[l];
               quot_in[l] = quot_cur[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (adv) begin
            valid_ff[g] <= vld_cur;
         end
         if (adv) begin
            tail_ff[g] <= tail_cur;
            rem_ff[g]  <= rem_in;
            quot_ff[g] <= quot_in;
         end
      end
   end

   assign out_valid = valid_ff[DV_STAGES-1];
   assign out_tail  = tail_ff[DV_STAGES-1];
   assign out_quot  = quot_ff[DV_STAGES-1];

endmodule
`default_nettype wire

@@ design/cubic_rbf_kernel_eval_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Words flow through products, sum, root, numerators, divider and output.
// Throughput: one word per cycle while the output is not stalled; the 21-stage
// square root and the 31-stage divider are fully pipelined, one bit per stage.
// The whole pipeline holds while a response word is stalled at the output.
// Reset is synchronous and clears all valid bits and both CSRs to zero.
module cubic_rbf_kernel_eval_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  crke_pkg::crke_req_type   req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output crke_pkg::crke_rsp_type   rsp_data,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [crke_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [crke_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import crke_pkg::*;

   logic adv;

   logic                  use_offset_ff;
   logic [23:0]           offset_square_ff;

   logic                  in_valid_ff;
   crke_req_type          in_data_ff;

   logic                  p1_valid_ff;
   logic signed [31:0]    p1_prod_ff [0:LANES-1];
   crke_req_type          p1_data_ff;

   logic                  p2_valid_ff;
   crke_item_type         p2_item_ff;
   logic [S_W-1:0]        s_in;

   logic                  sq_valid;
   logic [R_W-1:0]        sq_root;
   crke_item_type         sq_item;

   logic                      pr_valid_ff;
   crke_tail_type             pr_tail_ff;
   logic [LANES-1:0][N_W-1:0] pr_num_ff;
   crke_tail_type             pr_tail_in;
   logic [LANES-1:0][N_W-1:0] pr_num_in;

   logic                      dv_valid;
   crke_tail_type             dv_tail;
   logic [LANES-1:0][Q_W-1:0] dv_quot;

   logic                      f1_valid_ff;
   logic [S_W+R_W-1:0]        f1_kv_ff;
   logic signed [39:0]        f1_grad_ff [0:2];
   logic [32:0]               f1_diag_ff [0:2];
   logic [LANES-1:0][Q_W-1:0] f1_quot_ff;
   logic [LANES-1:0]          f1_pneg_ff;
   logic [LANES-1:0]          f1_ovf_ff;
   logic [R_W+1:0]            r3;

   logic                  f2_valid_ff;
   crke_rsp_type          f2_data_ff;
   crke_rsp_type          f2_data_in;
   logic signed [31:0]    grad_res [0:2];
   logic signed [31:0]    hess_res [0:LANES-1];

   logic                  rsp_valid_ff;
   crke_rsp_type          rsp_data_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_offset_ff    <= 1'b0;
         offset_square_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_USE_OFFSET:    use_offset_ff    <= csr_wdata[0];
            CSR_OFFSET_SQUARE: offset_square_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         pr_valid_ff  <= 1'b0;
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff  <= req_valid;
         p1_valid_ff  <= in_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
         pr_valid_ff  <= sq_valid;
         f1_valid_ff  <= dv_valid;
         f2_valid_ff  <= f1_valid_ff;
         rsp_valid_ff <= f2_valid_ff;
      end
   end

   // Products of the components
   always_ff @(posedge clock) begin
      if (adv) begin
         in_data_ff         <= req_data;
         p1_data_ff         <= in_data_ff;
         p1_prod_ff[LANE_XX] <= 32'(in_data_ff.pos_x) * 32'(in_data_ff.pos_x);
         p1_prod_ff[LANE_YY] <= 32'(in_data_ff.pos_y) * 32'(in_data_ff.pos_y);
         p1_prod_ff[LANE_ZZ] <= 32'(in_data_ff.pos_z) * 32'(in_data_ff.pos_z);
         p1_prod_ff[LANE_XY] <= 32'(in_data_ff.pos_x) * 32'(in_data_ff.pos_y);
         p1_prod_ff[LANE_XZ] <= 32'(in_data_ff.pos_x) * 32'(in_data_ff.pos_z);
         p1_prod_ff[LANE_YZ] <= 32'(in_data_ff.pos_y) * 32'(in_data_ff.pos_z);
      end
   end

   // Squared length in Q.24, with the offset moved up by eight bits.
   assign s_in = S_W'(p1_prod_ff[LANE_XX][30:0]) + S_W'(p1_prod_ff[LANE_YY][30:0])
               + S_W'(p1_prod_ff[LANE_ZZ][30:0])
               + (use_offset_ff ? {1'b0, offset_square_ff, 8'h00} : '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_item_ff.x <= p1_data_ff.pos_x;
         p2_item_ff.y <= p1_data_ff.pos_y;
         p2_item_ff.z <= p1_data_ff.pos_z;
         p2_item_ff.s <= s_in;
         for (int l = 0; l < LANES; l++) begin
            p2_item_ff.pmag[l] <= p1_prod_ff[l][31] ? P_W'(-p1_prod_ff[l])
                                                    : p1_prod_ff[l][P_W-1:0];
            p2_item_ff.pneg[l] <= p1_prod_ff[l][31];
         end
      end
   end

   crke_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (p2_valid_ff),
      .in_item   (p2_item_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_item  (sq_item)
   );

   // Numerators 3*|a*b|*2^8 and the overflow test: a quotient of 2^31 or
   // more saturates, so it is flagged here and the divider needs 31 bits.
   always_comb begin
      pr_tail_in.x    = sq_item.x;
      pr_tail_in.y    = sq_item.y;
      pr_tail_in.z    = sq_item.z;
      pr_tail_in.s    = sq_item.s;
      pr_tail_in.r    = (sq_root == '0) ? {{(R_W-1){1'b0}}, 1'b1} : sq_root;
      pr_tail_in.pneg = sq_item.pneg;
      for (int l = 0; l < LANES; l++) begin
         pr_num_in[l] = {(N_W-8)'({1'b0, sq_item.pmag[l], 1'b0}
                                 + {2'b00, sq_item.pmag[l]}), 8'h00};
         pr_tail_in.ovf[l] = {{(R_W-9){1'b0}}, pr_num_in[l][N_W-1:Q_W]} >= pr_tail_in.r;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_tail_ff <= pr_tail_in;
         pr_num_ff  <= pr_num_in;
      end
   end

   crke_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pr_valid_ff),
      .in_tail   (pr_tail_ff),
      .in_num    (pr_num_ff),
      .out_valid (dv_valid),
      .out_tail  (dv_tail),
      .out_quot  (dv_quot)
   );

   assign r3 = {2'b00, dv_tail.r} + {1'b0, dv_tail.r, 1'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_kv_ff      <= (S_W+R_W)'(dv_tail.s) * (S_W+R_W)'(dv_tail.r);
         f1_grad_ff[0] <= 40'($signed({1'b0, r3})) * 40'(dv_tail.x);
         f1_grad_ff[1] <= 40'($signed({1'b0, r3})) * 40'(dv_tail.y);
         f1_grad_ff[2] <= 40'($signed({1'b0, r3})) * 40'(dv_tail.z);
         for (int d = 0; d < 3; d++) begin
            f1_diag_ff[d] <= 33'(dv_quot[d]) + 33'(r3);
         end
         f1_quot_ff <= dv_quot;
         f1_pneg_ff <= dv_tail.pneg;
         f1_ovf_ff  <= dv_tail.ovf;
      end
   end

   // Rounding toward zero on the gradient; its magnitude stays below 2^26.
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         grad_res[d] = 32'((f1_grad_ff[d] + (f1_grad_ff[d][39] ? 40'sd4095 : 40'sd0))
                           >>> 12);
      end
      for (int d = 0; d < 3; d++) begin
         if (f1_ovf_ff[d] || f1_diag_ff[d][32:31] != 2'b00) begin
            hess_res[d] = 32'sh7FFF_FFFF;
         end else begin
            hess_res[d] = $signed(f1_diag_ff[d][31:0]);
         end
      end
      for (int l = LANE_XY; l < LANES; l++) begin
         if (f1_ovf_ff[l]) begin
            hess_res[l] = f1_pneg_ff[l] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else if (f1_pneg_ff[l]) begin
            hess_res[l] = -$signed({1'b0, f1_quot_ff[l]});
         end else begin
            hess_res[l] = $signed({1'b0, f1_quot_ff[l]});
         end
      end
      f2_data_in.kernel_value = {4'h0, f1_kv_ff[S_W+R_W-1:24]};
      f2_data_in.grad_x  = grad_res[0];
      f2_data_in.grad_y  = grad_res[1];
      f2_data_in.grad_z  = grad_res[2];
      f2_data_in.hess_xx = hess_res[LANE_XX];
      f2_data_in.hess_yy = hess_res[LANE_YY];
      f2_data_in.hess_zz = hess_res[LANE_ZZ];
      f2_data_in.hess_xy = hess_res[LANE_XY];
      f2_data_in.hess_xz = hess_res[LANE_XZ];
      f2_data_in.hess_yz = hess_res[LANE_YZ];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_data_ff  <= f2_data_in;
         rsp_data_ff <= f2_data_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_diag_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.hess_xx[31] && !rsp_data.hess_yy[31]
                    && !rsp_data.hess_zz[31])
      else $error("diagonal Hessian entry negative");

   a_kv_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kernel_value[33:30] == 4'h0)
      else $error("kernel value beyond product range");

   a_diag_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hess_xx != 32'sd0 && rsp_data.hess_yy != 32'sd0
                    && rsp_data.hess_zz != 32'sd0)
      else $error("diagonal Hessian entry zero despite radius floor");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while the output word is held");

endmodule
`default_nettype wire
